@@ hdl/tlr_pkg.sv @@
package tlr_pkg;

    localparam int COORD_BITS = 11;
    localparam int BRUSH_BITS = 6;
    localparam int PIXEL_BITS = COORD_BITS + 1;
    localparam int COLOR_BITS = 32;
    localparam int ERROR_BITS = COORD_BITS + 2;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [COORD_BITS-1:0]   x_start;
        logic [COORD_BITS-1:0]   y_start;
        logic [COORD_BITS-1:0]   x_end;
        logic [COORD_BITS-1:0]   y_end;
        logic [BRUSH_BITS-1:0]   brush_size;
        logic [COLOR_BITS-1:0]   line_color;
    } t_in_item;

    typedef struct packed {
        logic [PIXEL_BITS-1:0]   pixel_x;
        logic [PIXEL_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0]   pixel_color;
        logic                    last_pixel;
    } t_out_item;

    typedef struct packed {
        logic      emit;
        t_out_item pixel;
    } t_walk_result;

endpackage

@@ hdl/tlr_walker.sv @@
module tlr_walker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  tlr_pkg::t_in_item     i_item,
    output tlr_pkg::t_walk_result o_result
);
    import tlr_pkg::*;

    logic [COORD_BITS-1:0]        r_point_x, n_point_x;
    logic [COORD_BITS-1:0]        r_point_y, n_point_y;
    logic [COORD_BITS-1:0]        r_target_x, n_target_x;
    logic [COORD_BITS-1:0]        r_target_y, n_target_y;
    logic                         r_step_x_neg, n_step_x_neg;
    logic                         r_step_y_neg, n_step_y_neg;
    logic [COORD_BITS-1:0]        r_span_x, n_span_x;
    logic signed [COORD_BITS:0]   r_span_y_neg, n_span_y_neg;
    logic signed [ERROR_BITS-1:0] r_error, n_error;
    logic [BRUSH_BITS-1:0]        r_brush_col, n_brush_col;
    logic [BRUSH_BITS-1:0]        r_brush_row, n_brush_row;
    logic [BRUSH_BITS-1:0]        r_brush_edge, n_brush_edge;
    logic [COLOR_BITS-1:0]        r_color, n_color;
    logic                         r_busy, n_busy;

    logic                         w_load;
    logic                         w_tick;
    logic                         w_at_end;
    logic [BRUSH_BITS:0]          w_row_inc;
    logic [BRUSH_BITS:0]          w_col_inc;
    logic                         w_row_wrap;
    logic                         w_col_wrap;
    logic signed [ERROR_BITS:0]   w_twice;
    logic signed [ERROR_BITS:0]   w_spn_cmp;
    logic signed [ERROR_BITS:0]   w_sx_cmp;
    logic                         w_move_x;
    logic                         w_move_y;
    logic signed [ERROR_BITS-1:0] w_add_x;
    logic signed [ERROR_BITS-1:0] w_add_y;
    logic [COORD_BITS-1:0]        w_abs_x;
    logic [COORD_BITS-1:0]        w_abs_y;

    assign w_load = i_accept && (i_item.kind == KIND_LOAD);
    assign w_tick = i_accept && (i_item.kind == KIND_TICK) && r_busy;

    assign w_at_end   = (r_point_x == r_target_x) && (r_point_y == r_target_y);
    assign w_row_inc  = {1'b0, r_brush_row} + {{BRUSH_BITS{1'b0}}, 1'b1};
    assign w_col_inc  = {1'b0, r_brush_col} + {{BRUSH_BITS{1'b0}}, 1'b1};
    assign w_row_wrap = w_row_inc >= {1'b0, r_brush_edge};
    assign w_col_wrap = w_col_inc >= {1'b0, r_brush_edge};

    assign w_twice   = {r_error, 1'b0};
    assign w_spn_cmp = {{2{r_span_y_neg[COORD_BITS]}}, r_span_y_neg};
    assign w_sx_cmp  = {3'b000, r_span_x};
    assign w_move_x  = w_twice >= w_spn_cmp;
    assign w_move_y  = w_twice <= w_sx_cmp;
    assign w_add_x   = w_move_x ? {r_span_y_neg[COORD_BITS], r_span_y_neg} : '0;
    assign w_add_y   = w_move_y ? {2'b00, r_span_x} : '0;

    assign w_abs_x = (i_item.x_end >= i_item.x_start) ? i_item.x_end - i_item.x_start
                                                      : i_item.x_start - i_item.x_end;
    assign w_abs_y = (i_item.y_end >= i_item.y_start) ? i_item.y_end - i_item.y_start
                                                      : i_item.y_start - i_item.y_end;

    always_comb begin
        o_result.emit              = w_tick;
        o_result.pixel.pixel_x     = {1'b0, r_point_x}
                                   + {{(PIXEL_BITS-BRUSH_BITS){1'b0}}, r_brush_col};
        o_result.pixel.pixel_y     = {1'b0, r_point_y}
                                   + {{(PIXEL_BITS-BRUSH_BITS){1'b0}}, r_brush_row};
        o_result.pixel.pixel_color = r_color;
        o_result.pixel.last_pixel  = w_at_end && w_row_wrap && w_col_wrap;
    end

    always_comb begin
        n_point_x    = r_point_x;
        n_point_y    = r_point_y;
        n_target_x   = r_target_x;
        n_target_y   = r_target_y;
        n_step_x_neg = r_step_x_neg;
        n_step_y_neg = r_step_y_neg;
        n_span_x     = r_span_x;
        n_span_y_neg = r_span_y_neg;
        n_error      = r_error;
        n_brush_col  = r_brush_col;
        n_brush_row  = r_brush_row;
        n_brush_edge = r_brush_edge;
        n_color      = r_color;
        n_busy       = r_busy;
        if (w_load) begin
            n_point_x    = i_item.x_start;
            n_point_y    = i_item.y_start;
            n_target_x   = i_item.x_end;
            n_target_y   = i_item.y_end;
            n_step_x_neg = !(i_item.x_start < i_item.x_end);
            n_step_y_neg = !(i_item.y_start < i_item.y_end);
            n_span_x     = w_abs_x;
            n_span_y_neg = -$signed({1'b0, w_abs_y});
            n_error      = $signed({2'b00, w_abs_x}) - $signed({2'b00, w_abs_y});
            n_brush_col  = '0;
            n_brush_row  = '0;
            n_brush_edge = (i_item.brush_size == '0) ? BRUSH_BITS'(1) : i_item.brush_size;
            n_color      = i_item.line_color;
            n_busy       = 1'b1;
        end else if (w_tick) begin
            if (!w_row_wrap) begin
                n_brush_row = w_row_inc[BRUSH_BITS-1:0];
            end else begin
                n_brush_row = '0;
                if (!w_col_wrap) begin
                    n_brush_col = w_col_inc[BRUSH_BITS-1:0];
                end else begin
                    n_brush_col = '0;
                    if (w_at_end) begin
                        n_busy = 1'b0;
                    end else begin
                        n_error = r_error + w_add_x + w_add_y;
                        if (w_move_x) begin
                            n_point_x = r_step_x_neg ? r_point_x - COORD_BITS'(1)
                                                     : r_point_x + COORD_BITS'(1);
                        end
                        if (w_move_y) begin
                            n_point_y = r_step_y_neg ? r_point_y - COORD_BITS'(1)
                                                     : r_point_y + COORD_BITS'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_x    <= '0;
            r_point_y    <= '0;
            r_target_x   <= '0;
            r_target_y   <= '0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_span_x     <= '0;
            r_span_y_neg <= '0;
            r_error      <= '0;
            r_brush_col  <= '0;
            r_brush_row  <= '0;
            r_brush_edge <= BRUSH_BITS'(1);
            r_color      <= '0;
            r_busy       <= 1'b0;
        end else begin
            r_point_x    <= n_point_x;
            r_point_y    <= n_point_y;
            r_target_x   <= n_target_x;
            r_target_y   <= n_target_y;
            r_step_x_neg <= n_step_x_neg;
            r_step_y_neg <= n_step_y_neg;
            r_span_x     <= n_span_x;
            r_span_y_neg <= n_span_y_neg;
            r_error      <= n_error;
            r_brush_col  <= n_brush_col;
            r_brush_row  <= n_brush_row;
            r_brush_edge <= n_brush_edge;
            r_color      <= n_color;
            r_busy       <= n_busy;
        end
    end

endmodule

@@ hdl/tlr_out_reg.sv @@
module tlr_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  tlr_pkg::t_walk_result i_result,
    input  logic                  i_out_ready,
    output logic                  o_free,
    output logic                  o_out_valid,
    output tlr_pkg::t_out_item    o_out_item
);
    import tlr_pkg::*;

    logic      r_valid, n_valid;
    t_out_item r_item, n_item;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (i_out_ready) begin
            n_valid = 1'b0;
        end
        if (i_load && i_result.emit) begin
            n_valid = 1'b1;
            n_item  = i_result.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

@@ hdl/thick_line_rasterizer_unit.sv @@
// Thick line rasterizer: a Bresenham line walker that paints a square brush.
// The input channel (i_in_valid, o_in_ready, i_in_item) takes two kinds of
// item. A load item sets both endpoints, the brush edge and the color,
// replaces any line in progress and produces no pixel. A tick item produces
// the next pixel of the current line, or nothing when no line is active.
// Pixels leave on the output channel (o_out_valid, i_out_ready, o_out_item)
// with the brush row varying fastest, and last_pixel marks the final pixel
// of the brush at the end point.
// A pixel appears in the cycle after its tick item is accepted. One item is
// accepted every cycle while the output register is free; the walker state
// is updated with one add and compare per coordinate, and the output
// register decouples the two channels.
// When the receiver stalls, the pixel waits in the output register and
// o_in_ready drops until it is taken. A synchronous reset clears the walker
// to idle with a brush edge of one and empties the output register.
module thick_line_rasterizer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tlr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tlr_pkg::t_out_item o_out_item
);
    import tlr_pkg::*;

    logic         w_free;
    logic         w_accept;
    t_walk_result w_result;

    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    tlr_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_result (w_result)
    );

    tlr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_result    (w_result),
        .i_out_ready (i_out_ready),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/tlr_checker.sv @@
module tlr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input tlr_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input tlr_pkg::t_out_item o_out_item
);
    import tlr_pkg::*;

    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX =
        PIXEL_BITS'((1 << COORD_BITS) - 1 + (1 << BRUSH_BITS) - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("pixel item changed or vanished while stalled");

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output register occupancy");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_item.kind == KIND_LOAD) |=> !o_out_valid)
        else $error("load item produced a pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.pixel_x <= PIXEL_MAX) && (o_out_item.pixel_y <= PIXEL_MAX))
        else $error("pixel coordinate out of range");

endmodule

bind thick_line_rasterizer_unit tlr_checker u_tlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import tlr_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_ITEMS = 1000;
    localparam int MAX_REPORTS  = 40;

    class pixel_scoreboard;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
        bit                    step_x_negative;
        bit                    step_y_negative;
        int                    span_x;
        int                    span_y_negated;
        int                    error_term;
        int                    brush_col;
        int                    brush_row;
        int                    brush_edge;
        logic [COLOR_BITS-1:0] current_color;
        bit                    busy;
        t_out_item             expected_pixels[$];
        int                    failures;

        function new();
            point_x = '0;
            point_y = '0;
            target_x = '0;
            target_y = '0;
            step_x_negative = 0;
            step_y_negative = 0;
            span_x = 0;
            span_y_negated = 0;
            error_term = 0;
            brush_col = 0;
            brush_row = 0;
            brush_edge = 1;
            current_color = '0;
            busy = 0;
            failures = 0;
        endfunction

        function void walk_one_step();
            int twice;
            twice = error_term * 2;
            if (twice >= span_y_negated) begin
                error_term += span_y_negated;
                point_x = step_x_negative ? point_x - 1'b1 : point_x + 1'b1;
            end
            if (twice <= span_x) begin
                error_term += span_x;
                point_y = step_y_negative ? point_y - 1'b1 : point_y + 1'b1;
            end
        endfunction

        // Returns 1 when the accepted item produces a pixel.
        function bit note_item(t_in_item it);
            t_out_item px;
            bit        at_end;
            bit        brush_done;
            int        dy;
            if (it.kind == KIND_LOAD) begin
                point_x = it.x_start;
                point_y = it.y_start;
                target_x = it.x_end;
                target_y = it.y_end;
                step_x_negative = !(it.x_start < it.x_end);
                step_y_negative = !(it.y_start < it.y_end);
                span_x = (it.x_end >= it.x_start) ? int'(it.x_end) - int'(it.x_start)
                                                  : int'(it.x_start) - int'(it.x_end);
                dy = (it.y_end >= it.y_start) ? int'(it.y_end) - int'(it.y_start)
                                              : int'(it.y_start) - int'(it.y_end);
                span_y_negated = -dy;
                error_term = span_x + span_y_negated;
                brush_col = 0;
                brush_row = 0;
                brush_edge = (it.brush_size == 0) ? 1 : int'(it.brush_size);
                current_color = it.line_color;
                busy = 1;
                return 0;
            end
            if (!busy) begin
                return 0;
            end
            at_end = (point_x == target_x) && (point_y == target_y);
            brush_done = (brush_col + 1 >= brush_edge) && (brush_row + 1 >= brush_edge);
            px.pixel_x = {1'b0, point_x} + PIXEL_BITS'(brush_col);
            px.pixel_y = {1'b0, point_y} + PIXEL_BITS'(brush_row);
            px.pixel_color = current_color;
            px.last_pixel = at_end && brush_done;
            expected_pixels.push_back(px);
            brush_row++;
            if (brush_row >= brush_edge) begin
                brush_row = 0;
                brush_col++;
                if (brush_col >= brush_edge) begin
                    brush_col = 0;
                    if (at_end) begin
                        busy = 0;
                    end else begin
                        walk_one_step();
                    end
                end
            end
            return 1;
        endfunction

        function void report(string field, logic [COLOR_BITS-1:0] want,
                             logic [COLOR_BITS-1:0] got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want,
                         got);
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item want;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: unexpected pixel, expected none, actual %0h", $time, got);
                end
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x) begin
                report("pixel_x", want.pixel_x, got.pixel_x);
            end
            if (got.pixel_y !== want.pixel_y) begin
                report("pixel_y", want.pixel_y, got.pixel_y);
            end
            if (got.pixel_color !== want.pixel_color) begin
                report("pixel_color", want.pixel_color, got.pixel_color);
            end
            if (got.last_pixel !== want.last_pixel) begin
                report("last_pixel", want.last_pixel, got.last_pixel);
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    pixel_scoreboard sb = new();

    int  items_counted;
    int  pixels_seen;
    int  idle_cycles;
    int  hold_left;
    int  rx_phase;
    int  tx_phase;
    bit  rx_quiet;
    bit  tx_quiet;
    bit  long_hold_done;

    thick_line_rasterizer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pixel(o_out_item);
            pixels_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        hold_left = 0;
        rx_phase = 0;
        rx_quiet = 0;
        long_hold_done = 0;
        forever begin
            @(negedge i_clk);
            rx_phase++;
            if (rx_phase % 300 == 0) begin
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            if (!long_hold_done && pixels_seen >= 200) begin
                long_hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 4) == 0) begin
                    hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_item(t_kind k, int x0, int y0, int x1, int y1,
                                           int brush, logic [COLOR_BITS-1:0] color);
        t_in_item it;
        it.kind = k;
        it.x_start = COORD_BITS'(x0);
        it.y_start = COORD_BITS'(y0);
        it.x_end = COORD_BITS'(x1);
        it.y_end = COORD_BITS'(y1);
        it.brush_size = BRUSH_BITS'(brush);
        it.line_color = color;
        return it;
    endfunction

    function automatic t_in_item random_tick();
        return make_item(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) begin
            return 0;
        end
        if (v > (1 << COORD_BITS) - 1) begin
            return (1 << COORD_BITS) - 1;
        end
        return v;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        if (sb.note_item(it) || it.kind == KIND_LOAD) begin
            items_counted++;
        end
        tx_phase++;
        if (tx_phase % 150 == 0) begin
            tx_quiet = ($urandom_range(0, 2) == 0);
        end
    endtask

    task automatic lower_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic draw_line(int x0, int y0, int x1, int y1, int brush,
                             logic [COLOR_BITS-1:0] color, int max_ticks, int idle_ticks);
        int n;
        send_item(make_item(KIND_LOAD, x0, y0, x1, y1, brush, color));
        n = 0;
        while (sb.busy && n < max_ticks) begin
            send_item(random_tick());
            n++;
        end
        repeat (idle_ticks) send_item(random_tick());
    endtask

    initial begin
        int  r;
        int  x0;
        int  y0;
        int  x1;
        int  y1;
        int  brush;
        int  cap;
        bit  pause_done;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        items_counted = 0;
        pixels_seen = 0;
        idle_cycles = 0;
        tx_phase = 0;
        tx_quiet = 0;
        pause_done = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(random_tick());
        draw_line(2047, 0, 2047, 0, 0, 32'hFFFF_FFFF, 10, 1);
        draw_line(0, 0, 3, 1, 1, 32'h0000_0000, 10, 0);
        draw_line(2047, 2047, 2046, 2046, 2, 32'hA5A5_5A5A, 10, 0);
        draw_line(2047, 2047, 0, 0, 63, 32'h1234_5678, 3, 0);
        draw_line(5, 9, 5, 9, 0, 32'h8000_0001, 10, 1);

        while (items_counted < TARGET_ITEMS) begin
            if (!pause_done && items_counted >= TARGET_ITEMS / 2) begin
                pause_done = 1;
                lower_valid();
                while (sb.expected_pixels.size() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                x0 = ($urandom_range(0, 7) == 0) ? 2047 * $urandom_range(0, 1)
                                                 : $urandom_range(0, 2047);
                y0 = ($urandom_range(0, 7) == 0) ? 2047 * $urandom_range(0, 1)
                                                 : $urandom_range(0, 2047);
                x1 = clamp_coord($urandom_range(0, 1) ? x0 + $urandom_range(0, 12)
                                                      : x0 - $urandom_range(0, 12));
                y1 = clamp_coord($urandom_range(0, 1) ? y0 + $urandom_range(0, 12)
                                                      : y0 - $urandom_range(0, 12));
                brush = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 4);
                cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : 200;
                draw_line(x0, y0, x1, y1, brush, $urandom, cap,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            end else if (r < 90) begin
                draw_line($urandom_range(0, 2047), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 2047),
                          $urandom_range(0, 63), $urandom, $urandom_range(0, 8), 0);
            end else begin
                repeat ($urandom_range(1, 3)) send_item(random_tick());
            end
        end

        lower_valid();
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/tlr_pkg.sv
hdl/tlr_walker.sv
hdl/tlr_out_reg.sv
hdl/thick_line_rasterizer_unit.sv
hdl/tlr_checker.sv
tb/testbench.sv
